>>> rtl/core/kdlp_pkg.sv
`default_nettype none

package kdlp_pkg;

    localparam int NUM_KEYS_DEF = 16;
    localparam int KEY_W        = 16;
    localparam int TIME_W       = 32;
    localparam int CFG_W        = 16;
    localparam int CFG_INDEX_W  = 8;

    localparam logic [CFG_W-1:0] LOCKOUT_RST = 16'd50;
    localparam logic [CFG_W-1:0] HOLD_RST    = 16'd2000;

    localparam logic [CFG_INDEX_W-1:0] REG_LOCKOUT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD    = 8'd1;

    typedef enum logic [1:0] {
        MODE_RELEASED = 2'd0,
        MODE_PRESSED  = 2'd1,
        MODE_LONG     = 2'd2
    } key_mode_t;

    typedef struct packed {
        logic [CFG_W-1:0] lockout_ms;
        logic [CFG_W-1:0] hold_ms;
    } cfg_t;

    typedef struct packed {
        logic              fire;
        logic [TIME_W-1:0] now_ms;
    } scan_t;

    typedef struct packed {
        logic press;
        logic release_ev;
        logic long_ev;
    } key_event_t;

endpackage

`default_nettype wire

>>> rtl/core/kdlp_cfg.sv
`default_nettype none

module kdlp_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [kdlp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [kdlp_pkg::CFG_W-1:0]       cfg_data,
    output kdlp_pkg::cfg_t                      cfg
);
    import kdlp_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lockout_ms <= LOCKOUT_RST;
            cfg_reg.hold_ms    <= HOLD_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_LOCKOUT: cfg_reg.lockout_ms <= cfg_data;
                REG_HOLD:    cfg_reg.hold_ms    <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/kdlp_lane.sv
`default_nettype none

module kdlp_lane (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  kdlp_pkg::cfg_t      cfg,
    input  kdlp_pkg::scan_t     scan,
    input  wire logic           level,
    output kdlp_pkg::key_event_t ev
);
    import kdlp_pkg::*;

    key_mode_t         mode_reg, mode_next;
    logic [TIME_W-1:0] change_time_reg, change_time_next;
    logic [TIME_W-1:0] press_time_reg, press_time_next;
    logic [TIME_W-1:0] age, held_for;
    logic              eval, held;

    assign age      = scan.now_ms - change_time_reg;
    assign held_for = scan.now_ms - press_time_reg;
    assign eval     = age >= {{(TIME_W-CFG_W){1'b0}}, cfg.lockout_ms};
    assign held     = held_for >= {{(TIME_W-CFG_W){1'b0}}, cfg.hold_ms};

    always_comb begin
        mode_next = mode_reg;
        if (eval) begin
            unique case (mode_reg)
                MODE_RELEASED: if (level) mode_next = MODE_PRESSED;
                MODE_PRESSED: begin
                    if (!level)    mode_next = MODE_RELEASED;
                    else if (held) mode_next = MODE_LONG;
                end
                MODE_LONG:     if (!level) mode_next = MODE_RELEASED;
                default:       if (!level) mode_next = MODE_RELEASED;
            endcase
        end
    end

    always_comb begin
        ev.press      = (mode_reg == MODE_RELEASED) && (mode_next == MODE_PRESSED);
        ev.release_ev = (mode_reg != MODE_RELEASED) && (mode_next == MODE_RELEASED);
        ev.long_ev    = (mode_reg == MODE_PRESSED) && (mode_next == MODE_LONG);
        change_time_next = (mode_next != mode_reg) ? scan.now_ms : change_time_reg;
        press_time_next  = ev.press ? scan.now_ms : press_time_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_RELEASED;
            change_time_reg <= '0;
            press_time_reg  <= '0;
        end else if (scan.fire) begin
            mode_reg        <= mode_next;
            change_time_reg <= change_time_next;
            press_time_reg  <= press_time_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/keypad_debounce_long_press_unit.sv
// Each accepted scan is held in raw_reg/now_reg; its events are registered when the output is free, raising m_valid.
// Throughput: one scan per cycle while m_ready is high; all key lanes update in parallel.
// Reset: synchronous active-low aresetn; all keys released, time stamps zero,
// lockout 50 ms, hold 2000 ms, no request pending.
`default_nettype none

module keypad_debounce_long_press_unit #(
    parameter int NUM_KEYS = kdlp_pkg::NUM_KEYS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [kdlp_pkg::KEY_W-1:0]       s_raw_keys,
    input  wire logic [kdlp_pkg::TIME_W-1:0]      s_now_ms,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [kdlp_pkg::KEY_W-1:0]            m_press_events,
    output logic [kdlp_pkg::KEY_W-1:0]            m_release_events,
    output logic [kdlp_pkg::KEY_W-1:0]            m_long_events,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [kdlp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [kdlp_pkg::CFG_W-1:0]       cfg_data
);
    import kdlp_pkg::*;

    cfg_t              cfg;
    scan_t             scan;
    logic              in_valid_reg;
    logic [KEY_W-1:0]  raw_reg;
    logic [TIME_W-1:0] now_reg;
    logic              advance;
    logic              out_valid_reg;
    logic [KEY_W-1:0]  press_reg, release_reg, long_reg;
    logic [KEY_W-1:0]  press_next, release_next, long_next;
    logic [NUM_KEYS-1:0] levels;
    key_event_t          evs [NUM_KEYS];

    kdlp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready     = !in_valid_reg || advance;
    assign scan.fire   = advance;
    assign scan.now_ms = now_reg;

    always_comb begin
        for (int i = 0; i < NUM_KEYS; i++) begin
            levels[i] = (i < KEY_W) ? raw_reg[i % KEY_W] : 1'b0;
        end
    end

    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
        kdlp_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cfg     (cfg),
            .scan    (scan),
            .level   (levels[g]),
            .ev      (evs[g])
        );
    end

    always_comb begin
        press_next   = '0;
        release_next = '0;
        long_next    = '0;
        for (int i = 0; i < NUM_KEYS; i++) begin
            if (i < KEY_W) begin
                press_next[i % KEY_W]   = evs[i].press;
                release_next[i % KEY_W] = evs[i].release_ev;
                long_next[i % KEY_W]    = evs[i].long_ev;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            if (advance) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            raw_reg <= s_raw_keys;
            now_reg <= s_now_ms;
        end
        if (advance) begin
            press_reg   <= press_next;
            release_reg <= release_next;
            long_reg    <= long_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_press_events   = press_reg;
    assign m_release_events = release_reg;
    assign m_long_events    = long_reg;

endmodule

`default_nettype wire
